/* hdl/c3f_pkg.sv */
package c3f_pkg;
   localparam int MAX_WIDTH_DEF = 1024;
   localparam int PIX_W = 24;
   localparam int ROW_W = 12;
   localparam int COEF_W = 24;
   localparam int DIV_W = 16;
   localparam int SUM_W = 20;
   localparam int MAX_HEIGHT = 4095;

   localparam logic [2:0] REG_KTOP = 3'd0;
   localparam logic [2:0] REG_KMID = 3'd1;
   localparam logic [2:0] REG_KBOT = 3'd2;
   localparam logic [2:0] REG_DIV = 3'd3;
   localparam logic [2:0] REG_WIDTH = 3'd4;
   localparam logic [2:0] REG_HEIGHT = 3'd5;

   typedef struct packed {
      logic load;     // take new pixel, shift window and line stores
      logic mac;      // multiply-accumulate one tap
      logic clr;      // clear accumulators
      logic div_start;
      logic div_step;
      logic emit;     // move result into output register
   } cmd_type;

   typedef struct packed {
      logic interior;
      logic div_done;
      logic out_busy;
   } sts_type;
endpackage

/* hdl/c3f_ctrl.sv */
module c3f_ctrl
   import c3f_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   input  sts_type sts,
   output cmd_type cmd
);
   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_MAC  = 5'b00010,
      S_DIV  = 5'b00100,
      S_EMIT = 5'b01000,
      S_WAIT = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic [3:0] tap_ff, tap_in;

   always_comb begin
      state_in = state_ff;
      tap_in = tap_ff;
      cmd = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_WAIT;
            end
         end
         S_WAIT: begin
            if (sts.interior) begin
               cmd.clr = 1'b1;
               tap_in = 4'd0;
               state_in = S_MAC;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_MAC: begin
            // divider loads once the ninth tap has landed in the accumulators
            if (tap_ff == 4'd9) begin
               cmd.div_start = 1'b1;
               state_in = S_DIV;
            end else begin
               cmd.mac = 1'b1;
               tap_in = tap_ff + 4'd1;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_done) state_in = S_EMIT;
         end
         S_EMIT: begin
            if (!sts.out_busy) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         tap_ff <= '0;
      end else begin
         state_ff <= state_in;
         tap_ff <= tap_in;
      end
   end
endmodule

/* hdl/c3f_datapath.sv */
module c3f_datapath
   import c3f_pkg::*;
#(
   parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   output sts_type             sts,
   input  logic                first_pixel,
   input  logic [PIX_W-1:0]    pixel,
   input  logic [COEF_W-1:0]   krow_top,
   input  logic [COEF_W-1:0]   krow_mid,
   input  logic [COEF_W-1:0]   krow_bot,
   input  logic [DIV_W-1:0]    divisor,
   input  logic [10:0]         frame_width,
   input  logic [ROW_W-1:0]    frame_height,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [9:0]          rsp_col,
   output logic [ROW_W-1:0]    rsp_row,
   output logic [PIX_W-1:0]    rsp_pix
);
   localparam int AW = $clog2(MAX_WIDTH);
   localparam int CW = $clog2(MAX_WIDTH + 1);

   logic [PIX_W-1:0] upper_mem [MAX_WIDTH];
   logic [PIX_W-1:0] lower_mem [MAX_WIDTH];
   logic [PIX_W-1:0] win_ff [9];
   logic [PIX_W-1:0] pix_ff;
   logic [CW-1:0] col_ff, col_in, c_cur;
   logic [ROW_W-1:0] row_ff, row_in, r_cur;
   logic [CW-1:0] cpos_ff;
   logic [ROW_W-1:0] rpos_ff;
   logic [AW-1:0] idx;
   logic [CW-1:0] w_eff;
   logic [ROW_W-1:0] h_eff;
   logic [PIX_W-1:0] up_rd, lo_rd;
   logic interior_ff;

   // effective frame size
   always_comb begin
      w_eff = CW'(frame_width);
      if (frame_width < 11'd3) w_eff = CW'(3);
      else if ({21'd0, frame_width} > MAX_WIDTH) w_eff = CW'(MAX_WIDTH);
      h_eff = (frame_height < ROW_W'(3)) ? ROW_W'(3) : frame_height;
      if (frame_height == {ROW_W{1'b1}}) h_eff = ROW_W'(MAX_HEIGHT);
   end

   always_comb begin
      c_cur = first_pixel ? '0 : col_ff;
      r_cur = first_pixel ? '0 : row_ff;
      idx = (32'(c_cur) < MAX_WIDTH) ? c_cur[AW-1:0] : AW'(MAX_WIDTH - 1);
      if (c_cur + CW'(1) >= w_eff) begin
         col_in = '0;
         row_in = (r_cur + ROW_W'(1) >= h_eff) ? '0 : r_cur + ROW_W'(1);
      end else begin
         col_in = c_cur + CW'(1);
         row_in = r_cur;
      end
   end

   // line stores: read at load, written in the following cycle with same address
   logic [AW-1:0] idx_ff;
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         up_rd <= upper_mem[idx];
         lo_rd <= lower_mem[idx];
         idx_ff <= idx;
         pix_ff <= pixel;
      end
   end

   logic wb_ff;
   always_ff @(posedge clock) begin
      if (wb_ff) begin
         upper_mem[idx_ff] <= lo_rd;
         lower_mem[idx_ff] <= pix_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         wb_ff <= 1'b0;
         interior_ff <= 1'b0;
         for (int i = 0; i < 9; i++) win_ff[i] <= '0;
      end else begin
         wb_ff <= cmd.load;
         if (cmd.load) begin
            col_ff <= col_in;
            row_ff <= row_in;
            cpos_ff <= c_cur;
            rpos_ff <= r_cur;
            interior_ff <= (c_cur >= CW'(2)) && (r_cur >= ROW_W'(2)) &&
                           (c_cur < w_eff) && (r_cur < h_eff);
         end
         if (wb_ff) begin
            for (int k = 0; k < 3; k++) begin
               win_ff[k*3] <= win_ff[k*3+1];
               win_ff[k*3+1] <= win_ff[k*3+2];
            end
            win_ff[2] <= up_rd;
            win_ff[5] <= lo_rd;
            win_ff[8] <= pix_ff;
         end
      end
   end

   // one tap per cycle, three channels in parallel
   logic [3:0] tap_ff;
   logic [7:0] coef_b;
   logic [PIX_W-1:0] wsel;
   logic signed [SUM_W-1:0] acc_ff [3];
   logic [COEF_W-1:0] krow;

   always_comb begin
      case (tap_ff) inside
         4'd0, 4'd1, 4'd2: krow = krow_top;
         4'd3, 4'd4, 4'd5: krow = krow_mid;
         default:          krow = krow_bot;
      endcase
      case (tap_ff) inside
         4'd0, 4'd3, 4'd6: coef_b = krow[7:0];
         4'd1, 4'd4, 4'd7: coef_b = krow[15:8];
         default:          coef_b = krow[23:16];
      endcase
      wsel = win_ff[(tap_ff > 4'd8) ? 4'd8 : tap_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.clr) begin
         tap_ff <= '0;
         for (int i = 0; i < 3; i++) acc_ff[i] <= '0;
      end else if (cmd.mac) begin
         tap_ff <= tap_ff + 4'd1;
         for (int i = 0; i < 3; i++)
            acc_ff[i] <= acc_ff[i] +
               SUM_W'($signed({1'b0, wsel[i*8 +: 8]}) * $signed(coef_b));
      end
   end

   // restoring divider on magnitudes, one quotient bit per cycle, channels in parallel
   logic [SUM_W-1:0] mag_ff [3];
   logic [SUM_W-1:0] rem_ff [3];
   logic [2:0] neg_ff;
   logic [DIV_W-1:0] dv_ff;
   logic [4:0] dcnt_ff;
   logic [SUM_W:0] trial [3];

   always_comb begin
      for (int i = 0; i < 3; i++)
         trial[i] = {rem_ff[i], mag_ff[i][SUM_W-1]} - (SUM_W+1)'(dv_ff);
   end

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         dcnt_ff <= '0;
         dv_ff <= (divisor == '0) ? DIV_W'(1) : divisor;
      end else if (cmd.div_step && dcnt_ff != 5'(SUM_W)) begin
         dcnt_ff <= dcnt_ff + 5'd1;
      end
      for (int i = 0; i < 3; i++) begin
         if (cmd.div_start) begin
            neg_ff[i] <= acc_ff[i][SUM_W-1];
            mag_ff[i] <= acc_ff[i][SUM_W-1] ? SUM_W'(-acc_ff[i]) : acc_ff[i];
            rem_ff[i] <= '0;
         end else if (cmd.div_step && dcnt_ff != 5'(SUM_W)) begin
            if (!trial[i][SUM_W]) begin
               rem_ff[i] <= trial[i][SUM_W-1:0];
               mag_ff[i] <= {mag_ff[i][SUM_W-2:0], 1'b1};
            end else begin
               rem_ff[i] <= {rem_ff[i][SUM_W-2:0], mag_ff[i][SUM_W-1]};
               mag_ff[i] <= {mag_ff[i][SUM_W-2:0], 1'b0};
            end
         end
      end
   end

   logic [PIX_W-1:0] clamped;
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (neg_ff[i] && mag_ff[i] != '0) clamped[i*8 +: 8] = 8'd0;
         else if (mag_ff[i] > SUM_W'(255)) clamped[i*8 +: 8] = 8'd255;
         else clamped[i*8 +: 8] = mag_ff[i][7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid <= 1'b0;
      end else if (cmd.emit) begin
         rsp_tvalid <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid <= 1'b0;
      end
      if (cmd.emit) begin
         rsp_col <= 10'(cpos_ff - CW'(1));
         rsp_row <= rpos_ff - ROW_W'(1);
         rsp_pix <= clamped;
      end
   end

   assign sts.interior = interior_ff;
   assign sts.div_done = (dcnt_ff == 5'(SUM_W));
   assign sts.out_busy = rsp_tvalid && !rsp_tready;
endmodule

/* hdl/conv3x3_rgb_filter_top.sv */
// 3x3 RGB convolution filter.
// req_ channel takes one raster-order pixel word; tuser marks the frame's
// top-left pixel. rsp_ channel returns one filtered pixel with its column
// and row for each interior position; border positions give no word.
// csr_ channel writes kernel rows, divisor and frame size; write only
// while the block is idle.
// Sequence: a pixel is taken and then checked for an interior position; if it
// yields no word the next pixel is taken. An interior pixel then steps through
// the nine taps (one kernel tap per cycle on a shared multiply-accumulate), loads
// the divider, runs the bit-serial divide and emits before the next pixel is taken.
// The result sits in an output register; a stalled receiver holds it and
// the block keeps taking pixels until the next result is ready to go out.
// Reset restores identity kernel, divisor 1, 640x480 frame and zeroes the
// counters and window; line stores hold no defined data until written.
module conv3x3_rgb_filter_top
   import c3f_pkg::*;
#(
   parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // pixel_red, pixel_green, pixel_blue
   input  logic        req_tuser,   // first_pixel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // out_col, out_row, out_red, out_green, out_blue, pad
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [23:0] csr_data
);
   cmd_type cmd;
   sts_type sts;
   logic [COEF_W-1:0] ktop_ff, kmid_ff, kbot_ff;
   logic [DIV_W-1:0] div_ff;
   logic [10:0] width_ff;
   logic [ROW_W-1:0] height_ff;
   logic [9:0] col;
   logic [ROW_W-1:0] row;
   logic [PIX_W-1:0] pix;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ktop_ff <= '0;
         kmid_ff <= 24'd256;
         kbot_ff <= '0;
         div_ff <= 16'd1;
         width_ff <= 11'd640;
         height_ff <= 12'd480;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_KTOP:   ktop_ff <= csr_data;
            REG_KMID:   kmid_ff <= csr_data;
            REG_KBOT:   kbot_ff <= csr_data;
            REG_DIV:    div_ff <= csr_data[15:0];
            REG_WIDTH:  width_ff <= csr_data[10:0];
            REG_HEIGHT: height_ff <= csr_data[11:0];
            default: ;
         endcase
      end
   end

   c3f_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_tvalid(req_tvalid),
      .req_tready(req_tready), .sts(sts), .cmd(cmd)
   );

   c3f_datapath #(.MAX_WIDTH(MAX_WIDTH)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .first_pixel(req_tuser), .pixel(req_tdata),
      .krow_top(ktop_ff), .krow_mid(kmid_ff), .krow_bot(kbot_ff),
      .divisor(div_ff), .frame_width(width_ff), .frame_height(height_ff),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_col(col), .rsp_row(row), .rsp_pix(pix)
   );

   assign rsp_tdata = {2'b00, pix, row, col};

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result word changed");
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> !(rsp_tvalid && !rsp_tready))
      else $error("result overwritten");
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.mac, cmd.div_step, cmd.emit}))
      else $error("conflicting datapath commands");
endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
   import c3f_pkg::*;

   typedef struct packed {
      logic       first;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_type;

   // lowest bits first: col, row, red, green, blue
   typedef struct packed {
      logic [7:0]  blue;
      logic [7:0]  green;
      logic [7:0]  red;
      logic [11:0] row;
      logic [9:0]  col;
   } filt_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [23:0] csr_data = '0;

   conv3x3_rgb_filter_top dut (.*);

   always #10 clock = ~clock;

   // predictor state
   logic [23:0] k_top, k_mid, k_bot;
   logic [15:0] div_reg;
   logic [10:0] width_reg;
   logic [11:0] height_reg;
   logic [23:0] line_up [MAX_WIDTH_DEF];
   logic [23:0] line_lo [MAX_WIDTH_DEF];
   logic [23:0] win [9];
   int unsigned col_cnt, row_cnt;

   pixel_type pending_pixels[$];
   filt_type  expected_filt[$];
   int     mismatches = 0;
   int     got_count = 0;
   int     pixels_sent = 0;
   bit     quiet = 0;      // no idling while set
   bit     feed_hold = 0;

   function automatic logic [7:0] filter_channel(int shift);
      logic [23:0] rows [3];
      int sum, q, d;
      sum = 0;
      rows[0] = k_top; rows[1] = k_mid; rows[2] = k_bot;
      for (int ky = 0; ky < 3; ky++)
         for (int kx = 0; kx < 3; kx++)
            sum += int'(win[ky*3+kx][shift +: 8]) *
                   int'($signed(rows[ky][8*kx +: 8]));
      d = (div_reg == 0) ? 1 : int'(div_reg);
      q = sum / d;
      if (q > 255) q = 255;
      if (q < 0) q = 0;
      return q[7:0];
   endfunction

   task automatic predict_pixel(pixel_type p);
      int unsigned w, h, c, r, idx;
      logic [23:0] pix;
      filt_type f;
      w = width_reg; h = height_reg;
      if (w < 3) w = 3;
      if (w > MAX_WIDTH_DEF) w = MAX_WIDTH_DEF;
      if (h < 3) h = 3;
      if (h > MAX_HEIGHT) h = MAX_HEIGHT;
      if (p.first) begin
         col_cnt = 0; row_cnt = 0;
      end
      c = col_cnt; r = row_cnt;
      pix = {p.blue, p.green, p.red};
      idx = (c < MAX_WIDTH_DEF) ? c : MAX_WIDTH_DEF - 1;
      for (int k = 0; k < 3; k++) begin
         win[k*3] = win[k*3+1];
         win[k*3+1] = win[k*3+2];
      end
      win[2] = line_up[idx]; win[5] = line_lo[idx]; win[8] = pix;
      line_up[idx] = line_lo[idx];
      line_lo[idx] = pix;
      if (c >= 2 && r >= 2 && c < w && r < h) begin
         f.col = 10'(c - 1); f.row = 12'(r - 1);
         f.red = filter_channel(0);
         f.green = filter_channel(8);
         f.blue = filter_channel(16);
         expected_filt.push_back(f);
      end
      if (c + 1 >= w) begin
         col_cnt = 0;
         row_cnt = (r + 1 >= h) ? 0 : r + 1;
      end else begin
         col_cnt = c + 1;
      end
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) begin
            predict_pixel(pixel_type'({req_tuser, req_tdata[7:0], req_tdata[15:8],
                                       req_tdata[23:16]}));
            pixels_sent++;
         end
         if (pending_pixels.size() > 0 && !feed_hold &&
             (quiet || $urandom_range(99) >= 26)) begin
            pixel_type p;
            p = pending_pixels.pop_front();
            req_tvalid <= 1'b1;
            req_tuser  <= p.first;
            req_tdata  <= {p.blue, p.green, p.red};
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            filt_type got, want;
            got = rsp_tdata[45:0];
            got_count++;
            if (expected_filt.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected word %h", got);
            end else begin
               want = expected_filt.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("word %0d: want c%0d r%0d rgb %h %h %h, got c%0d r%0d rgb %h %h %h",
                              got_count, want.col, want.row, want.red, want.green,
                              want.blue, got.col, got.row, got.red, got.green, got.blue);
               end
            end
         end
         rsp_tready <= quiet || ($urandom_range(99) >= 26);
      end
   end

   task automatic csr_write(logic [2:0] idx, logic [23:0] val);
      @(posedge clock);
      csr_valid <= 1'b1; csr_index <= idx; csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         REG_KTOP:   k_top = val;
         REG_KMID:   k_mid = val;
         REG_KBOT:   k_bot = val;
         REG_DIV:    div_reg = val[15:0];
         REG_WIDTH:  width_reg = val[10:0];
         REG_HEIGHT: height_reg = val[11:0];
         default: ;
      endcase
   endtask

   task automatic drain();
      while (pending_pixels.size() > 0 || req_tvalid || expected_filt.size() > 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   // whole frames keep line stores defined before they are read
   task automatic queue_frame(int w, int h, int mode);
      pixel_type p;
      for (int i = 0; i < w * h; i++) begin
         p.first = (i == 0);
         case (mode)
            0: p[23:0] = '0;
            1: p[23:0] = '1;
            2: p[23:0] = (i % 2) ? 24'hFFFFFF : 24'h000000;
            default: p[23:0] = 24'($urandom);
         endcase
         pending_pixels.push_back(p);
      end
   endtask

   function automatic logic [23:0] rand_row();
      case ($urandom_range(3))
         0: return 24'h808080;
         1: return 24'h7F7F7F;
         default: return 24'($urandom);
      endcase
   endfunction

   initial begin
      k_top = 0; k_mid = 24'h000100; k_bot = 0;
      div_reg = 1; width_reg = 640; height_reg = 480;
      for (int i = 0; i < MAX_WIDTH_DEF; i++) begin
         line_up[i] = 0; line_lo[i] = 0;
      end
      for (int i = 0; i < 9; i++) win[i] = 0;
      col_cnt = 0; row_cnt = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // identity kernel on tiny frames, extremes of pixel values
      csr_write(REG_WIDTH, 24'd3);
      csr_write(REG_HEIGHT, 24'd3);
      queue_frame(3, 3, 0);
      queue_frame(3, 3, 1);
      drain();
      // positive extreme kernel, divisor 1: clamps high
      csr_write(REG_KTOP, 24'h7F7F7F);
      csr_write(REG_KMID, 24'h7F7F7F);
      csr_write(REG_KBOT, 24'h7F7F7F);
      csr_write(REG_WIDTH, 24'd4);
      queue_frame(4, 3, 2);
      drain();
      // negative middle kernel row on random pixels; zero divisor means 1
      csr_write(REG_KMID, 24'h808080);
      csr_write(REG_DIV, 24'd0);
      queue_frame(4, 3, 3);
      drain();

      // random phases
      for (int ph = 0; ph < 12; ph++) begin
         int w, h;
         csr_write(REG_KTOP, rand_row());
         csr_write(REG_KMID, rand_row());
         csr_write(REG_KBOT, rand_row());
         case (ph % 4)
            0: csr_write(REG_DIV, 24'h00FFFF);
            1: csr_write(REG_DIV, 24'd1);
            default: csr_write(REG_DIV, 24'($urandom_range(1, 600)));
         endcase
         if (ph == 5) begin
            w = 40; h = 3;
         end else begin
            w = $urandom_range(3, 9); h = $urandom_range(3, 7);
         end
         csr_write(REG_WIDTH, 24'(w));
         csr_write(REG_HEIGHT, 24'(h));
         quiet = (ph == 7);
         queue_frame(w, h, 3);
         if (ph == 3) begin
            // stop feeding until the block has returned everything
            repeat (30) @(posedge clock);
            feed_hold = 1;
            while (req_tvalid || expected_filt.size() > 0) @(posedge clock);
            feed_hold = 0;
         end
         drain();
         quiet = 0;
      end
      // out-of-range sizes clamp up to 3x3
      csr_write(REG_WIDTH, 24'd0);
      csr_write(REG_HEIGHT, 24'd0);
      queue_frame(3, 3, 3);
      queue_frame(3, 3, 3);
      drain();
      // height above 4095 cannot be written (12 bits); top value exercised
      csr_write(REG_WIDTH, 24'h0007FF);
      csr_write(REG_HEIGHT, 24'h000FFF);
      csr_write(REG_DIV, 24'h000001);
      queue_frame(40, 1, 3);
      drain();

      $display("covered %0d pixels, %0d filtered words, kernel and size extremes",
               pixels_sent, got_count);
      if (mismatches == 0 && expected_filt.size() == 0)
         $display("conv3x3_rgb_filter_top: match");
      else
         $display("conv3x3_rgb_filter_top: mismatch");
      $finish;
   end

   initial begin
      #50ms;
      $display("conv3x3_rgb_filter_top: mismatch");
      $finish;
   end

endmodule

/* conv3x3_rgb_filter_top.f */
hdl/c3f_pkg.sv
hdl/c3f_ctrl.sv
hdl/c3f_datapath.sv
hdl/conv3x3_rgb_filter_top.sv
tb/sv/tb_top.sv
